// ===== rtl/prx_pkg.sv =====
// ----------------------------------------------------------------------------
// prx_pkg
// Shared types, constants and width helpers for the ribbon expander.
// ----------------------------------------------------------------------------
package prx_pkg;

    localparam int COORD_BITS_DEF    = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // quotient width of the shared divider (unit vector and half-width)
    localparam int Q_BITS   = 16;
    localparam int UNIT_MAX = 32767;
    localparam int THK_BITS = 16;
    localparam int C_BITS   = 24;

    localparam logic [15:0] SPAN_RESET = 16'd60;
    localparam logic [7:0]  NEAR_RESET = 8'd20;
    localparam logic [7:0]  FAR_RESET  = 8'd2;

    localparam logic [1:0] CFG_SPAN = 2'd0;
    localparam logic [1:0] CFG_NEAR = 2'd1;
    localparam logic [1:0] CFG_FAR  = 2'd2;

    localparam logic [1:0] COMP_X   = 2'd0;
    localparam logic [1:0] COMP_Y   = 2'd1;
    localparam logic [1:0] COMP_Z   = 2'd2;
    localparam logic [1:0] COMP_AUX = 2'd3;

    localparam logic [3:0] OP_NONE     = 4'd0;
    localparam logic [3:0] OP_FIRST    = 4'd1;
    localparam logic [3:0] OP_SEG      = 4'd2;
    localparam logic [3:0] OP_SQ       = 4'd3;
    localparam logic [3:0] OP_ROOT_INI = 4'd4;
    localparam logic [3:0] OP_ROOT     = 4'd5;
    localparam logic [3:0] OP_DIV_INI  = 4'd6;
    localparam logic [3:0] OP_DIV      = 4'd7;
    localparam logic [3:0] OP_DIV_END  = 4'd8;
    localparam logic [3:0] OP_THK_MUL  = 4'd9;
    localparam logic [3:0] OP_THK_FAR  = 4'd10;
    localparam logic [3:0] OP_SCALE    = 4'd11;
    localparam logic [3:0] OP_EMIT     = 4'd12;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] comp;
    } prx_cmd_t;

    typedef struct packed {
        logic have_prev;
        logic len_zero;
        logic span_zero;
    } prx_status_t;

    // digit pairs of the square root of sum * 2^16; also the length width
    function automatic int root_pairs(input int coord_bits);
        return coord_bits + 10;
    endfunction

endpackage

// ===== rtl/polyline_ribbon_expander.sv =====
// ----------------------------------------------------------------------------
// polyline_ribbon_expander
// Turns a stream of 3D points into left/right ribbon vertex pairs.
// ----------------------------------------------------------------------------
// One item in, at most one item out: the first point of a strip gives nothing;
// any later point gives a vertex pair after COORD_BITS + 10 root steps, three
// unit divisions, a half-width division and squaring, scaling and hand-off (a
// zero-length segment skips the unit divisions, a zero span the half-width
// division). The square root is digit-serial, and a single restoring divider
// serves all divisions. A finished item waits in the output register while
// the next point is taken.
// Configuration writes are accepted every cycle and belong in idle periods.
module polyline_ribbon_expander #(
    parameter int COORD_BITS    = prx_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = prx_pkg::FRACTION_BITS_DEF,
    localparam int OUT_BITS       = COORD_BITS + FRACTION_BITS + 1,
    localparam int IN_TDATA_BITS  = ((3 * COORD_BITS + 7) / 8) * 8,
    localparam int OUT_TDATA_BITS = ((6 * OUT_BITS + 7) / 8) * 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // point_x, point_y, point_z
    input  logic [IN_TDATA_BITS-1:0] s_axis_tdata,
    // strip_start
    input  logic                     s_axis_tuser,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // left_x, left_y, left_z, right_x, right_y, right_z
    output logic [OUT_TDATA_BITS-1:0] m_axis_tdata,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [15:0]              cfg_data
);

    prx_pkg::prx_cmd_t    cmd;
    prx_pkg::prx_status_t status;
    logic signed [OUT_BITS-1:0] left_x, left_y, left_z, right_x, right_y, right_z;

    prx_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_start  (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .status    (status),
        .cmd       (cmd)
    );

    prx_datapath #(
        .COORD_BITS    (COORD_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .OUT_BITS      (OUT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .point_x   (s_axis_tdata[COORD_BITS-1:0]),
        .point_y   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .point_z   (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
        .left_x    (left_x),
        .left_y    (left_y),
        .left_z    (left_z),
        .right_x   (right_x),
        .right_y   (right_y),
        .right_z   (right_z)
    );

    assign cfg_ready    = 1'b1;
    assign m_axis_tdata = OUT_TDATA_BITS'({right_z, right_y, right_x, left_z, left_y, left_x});

endmodule

// ===== rtl/prx_ctrl.sv =====
// ----------------------------------------------------------------------------
// prx_ctrl
// Sequencer: handshakes, step counting and command issue to the datapath.
// ----------------------------------------------------------------------------
module prx_ctrl #(
    parameter int COORD_BITS = prx_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  logic                 in_start,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  prx_pkg::prx_status_t status,
    output prx_pkg::prx_cmd_t    cmd
);

    localparam int PAIRS    = prx_pkg::root_pairs(COORD_BITS);
    localparam int CNT_BITS = $clog2(PAIRS);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SQ     = 4'd1;
    localparam logic [3:0] S_RINIT  = 4'd2;
    localparam logic [3:0] S_ROOT   = 4'd3;
    localparam logic [3:0] S_LCHK   = 4'd4;
    localparam logic [3:0] S_DINIT  = 4'd5;
    localparam logic [3:0] S_DIV    = 4'd6;
    localparam logic [3:0] S_DSTORE = 4'd7;
    localparam logic [3:0] S_TMUL   = 4'd8;
    localparam logic [3:0] S_TFAR   = 4'd9;
    localparam logic [3:0] S_SCALE  = 4'd10;
    localparam logic [3:0] S_DONE   = 4'd11;

    logic [3:0]          state_reg, state_next;
    logic [1:0]          comp_reg, comp_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            comp_reg      <= prx_pkg::COMP_X;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            comp_reg      <= comp_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        comp_next      = comp_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = prx_pkg::OP_NONE;
        cmd.comp       = comp_reg;
        in_ready       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_start || !status.have_prev)
                    begin
                        cmd.op = prx_pkg::OP_FIRST;
                    end
                    else
                    begin
                        cmd.op     = prx_pkg::OP_SEG;
                        comp_next  = prx_pkg::COMP_X;
                        state_next = S_SQ;
                    end
                end
            end
            S_SQ:
            begin
                cmd.op    = prx_pkg::OP_SQ;
                comp_next = comp_reg + 2'd1;
                if (comp_reg == prx_pkg::COMP_AUX)
                begin
                    state_next = S_RINIT;
                end
            end
            S_RINIT:
            begin
                cmd.op     = prx_pkg::OP_ROOT_INI;
                cnt_next   = '0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                cmd.op   = prx_pkg::OP_ROOT;
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(PAIRS - 1))
                begin
                    state_next = S_LCHK;
                end
            end
            S_LCHK:
            begin
                comp_next = prx_pkg::COMP_X;
                if (!status.len_zero)
                begin
                    state_next = S_DINIT;
                end
                else if (status.span_zero)
                begin
                    state_next = S_TFAR;
                end
                else
                begin
                    state_next = S_TMUL;
                end
            end
            S_DINIT:
            begin
                cmd.op     = prx_pkg::OP_DIV_INI;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.op   = prx_pkg::OP_DIV;
                cnt_next = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(prx_pkg::Q_BITS - 1))
                begin
                    state_next = S_DSTORE;
                end
            end
            S_DSTORE:
            begin
                cmd.op = prx_pkg::OP_DIV_END;
                if (comp_reg == prx_pkg::COMP_AUX)
                begin
                    comp_next  = prx_pkg::COMP_X;
                    state_next = S_SCALE;
                end
                else if (comp_reg == prx_pkg::COMP_Z)
                begin
                    state_next = status.span_zero ? S_TFAR : S_TMUL;
                end
                else
                begin
                    comp_next  = comp_reg + 2'd1;
                    state_next = S_DINIT;
                end
            end
            S_TMUL:
            begin
                cmd.op     = prx_pkg::OP_THK_MUL;
                comp_next  = prx_pkg::COMP_AUX;
                state_next = S_DINIT;
            end
            S_TFAR:
            begin
                cmd.op     = prx_pkg::OP_THK_FAR;
                comp_next  = prx_pkg::COMP_X;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op    = prx_pkg::OP_SCALE;
                comp_next = comp_reg + 2'd1;
                if (comp_reg == prx_pkg::COMP_AUX)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = prx_pkg::OP_EMIT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

    a_root_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> (cnt_reg < CNT_BITS'(PAIRS)))
        else $error("root step count out of range");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && !out_ready) |=> (state_reg == S_DONE))
        else $error("result overwritten before delivery");

    a_seg_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == prx_pkg::OP_SEG) |=> (state_reg == S_SQ && comp_reg == prx_pkg::COMP_X))
        else $error("segment did not start squaring");

    a_emit_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == prx_pkg::OP_EMIT) |=> (out_valid_reg && state_reg == S_IDLE))
        else $error("emit without valid result");

endmodule

// ===== rtl/prx_datapath.sv =====
// ----------------------------------------------------------------------------
// prx_datapath
// Point store, squarer, digit-serial root, shared divider, scaler, result regs.
// ----------------------------------------------------------------------------
module prx_datapath #(
    parameter int COORD_BITS    = prx_pkg::COORD_BITS_DEF,
    parameter int FRACTION_BITS = prx_pkg::FRACTION_BITS_DEF,
    parameter int OUT_BITS      = COORD_BITS + FRACTION_BITS + 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  prx_pkg::prx_cmd_t           cmd,
    output prx_pkg::prx_status_t        status,
    input  logic                        cfg_valid,
    input  logic [1:0]                  cfg_index,
    input  logic [15:0]                 cfg_data,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    output logic signed [OUT_BITS-1:0]  left_x,
    output logic signed [OUT_BITS-1:0]  left_y,
    output logic signed [OUT_BITS-1:0]  left_z,
    output logic signed [OUT_BITS-1:0]  right_x,
    output logic signed [OUT_BITS-1:0]  right_y,
    output logic signed [OUT_BITS-1:0]  right_z
);

    localparam int C        = COORD_BITS;
    localparam int D_BITS   = C + 1;
    localparam int SQ_BITS  = 2 * C + 2;
    localparam int SUM_BITS = 2 * C + 4;
    localparam int PAIRS    = prx_pkg::root_pairs(C);
    localparam int LEN_BITS = PAIRS;
    localparam int RAD_BITS = 2 * PAIRS;
    localparam int DIV_BITS = LEN_BITS;
    localparam int NUM_BITS = C + 25;
    localparam int QB       = prx_pkg::Q_BITS;
    localparam int CB       = prx_pkg::C_BITS;
    localparam int CMP_BITS = C + 24;
    localparam int P_BITS   = 34;
    localparam int SH       = 23 - FRACTION_BITS;

    // configuration
    logic [15:0] span_reg;
    logic [7:0]  near_reg, far_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            span_reg <= prx_pkg::SPAN_RESET;
            near_reg <= prx_pkg::NEAR_RESET;
            far_reg  <= prx_pkg::FAR_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                prx_pkg::CFG_SPAN: span_reg <= cfg_data;
                prx_pkg::CFG_NEAR: near_reg <= cfg_data[7:0];
                prx_pkg::CFG_FAR:  far_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // previous point and strip flag
    logic                have_reg;
    logic signed [C-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic signed [C-1:0] cur_x_reg, cur_y_reg, cur_z_reg;
    logic signed [D_BITS-1:0] d_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else if (cmd.op == prx_pkg::OP_FIRST)
        begin
            have_reg <= 1'b1;
        end
    end

    // working registers
    logic [SQ_BITS-1:0]  sq_reg;
    logic [SUM_BITS-1:0] sum_reg;
    logic [RAD_BITS-1:0] rad_reg;
    logic [LEN_BITS+1:0] rrem_reg;
    logic [LEN_BITS-1:0] root_reg;
    logic [QB-1:0]       num_reg;
    logic [DIV_BITS-1:0] rem_reg, dvs_reg;
    logic [QB-1:0]       quo_reg;
    logic signed [15:0]  u_reg [3];
    logic [31:0]         thk_prod_reg;
    logic [prx_pkg::THK_BITS-1:0] t_reg;
    logic signed [32:0]  prod_reg;
    logic [1:0]          prod_comp_reg;
    logic signed [OUT_BITS-1:0] pos_reg [3];
    logic signed [OUT_BITS-1:0] neg_reg [3];
    logic signed [OUT_BITS-1:0] lx_reg, ly_reg, lz_reg, rx_reg, ry_reg, rz_reg;

    // combinational helpers
    logic signed [D_BITS-1:0] d_sel;
    logic [D_BITS-1:0]        d_mag;
    logic signed [15:0]       u_sel;
    logic [LEN_BITS+3:0]      rsh, rtrial;
    logic [DIV_BITS:0]        dtrial;
    logic [NUM_BITS-1:0]      n_val;
    logic [CMP_BITS-1:0]      lim_w, len_w;
    logic [CB-1:0]            c_val;
    logic signed [8:0]        tdiff;
    logic [7:0]               tdiff_mag;
    logic [QB-1:0]            q_clamp;
    logic signed [16:0]       t_sum;
    logic signed [P_BITS-1:0] p_pos, p_neg;

    always_comb
    begin
        d_sel     = (cmd.comp == prx_pkg::COMP_AUX) ? '0 : d_reg[cmd.comp];
        d_mag     = d_sel[D_BITS-1] ? D_BITS'(-d_sel) : D_BITS'(d_sel);
        u_sel     = (cmd.comp == prx_pkg::COMP_AUX) ? '0 : u_reg[cmd.comp];
        rsh       = {rrem_reg, rad_reg[RAD_BITS-1 -: 2]};
        rtrial    = (LEN_BITS + 4)'({root_reg, 2'b01});
        dtrial    = {rem_reg, num_reg[QB-1]};
        lim_w     = CMP_BITS'({span_reg, 8'd0});
        len_w     = CMP_BITS'(root_reg);
        c_val     = (len_w < lim_w) ? CB'(len_w) : CB'(lim_w);
        tdiff     = $signed({1'b0, far_reg}) - $signed({1'b0, near_reg});
        tdiff_mag = tdiff[8] ? 8'(-tdiff) : 8'(tdiff);
        if (cmd.comp == prx_pkg::COMP_AUX)
        begin
            n_val = NUM_BITS'(thk_prod_reg) + NUM_BITS'(span_reg >> 1);
        end
        else
        begin
            n_val = (NUM_BITS'(d_mag) << 23) + NUM_BITS'(root_reg >> 1);
        end
        q_clamp = (quo_reg > QB'(prx_pkg::UNIT_MAX)) ? QB'(prx_pkg::UNIT_MAX) : quo_reg;
        t_sum   = tdiff[8] ? (17'(signed'({1'b0, near_reg, 8'd0})) - signed'({1'b0, quo_reg}))
                           : (17'(signed'({1'b0, near_reg, 8'd0})) + signed'({1'b0, quo_reg}));
        p_pos   = (P_BITS'(prod_reg) + (P_BITS'(1) <<< (SH - 1))) >>> SH;
        p_neg   = (-P_BITS'(prod_reg) + (P_BITS'(1) <<< (SH - 1))) >>> SH;
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            prx_pkg::OP_FIRST:
            begin
                prev_x_reg <= point_x;
                prev_y_reg <= point_y;
                prev_z_reg <= point_z;
            end
            prx_pkg::OP_SEG:
            begin
                cur_x_reg <= point_x;
                cur_y_reg <= point_y;
                cur_z_reg <= point_z;
                d_reg[0]  <= D_BITS'(point_x) - D_BITS'(prev_x_reg);
                d_reg[1]  <= D_BITS'(point_y) - D_BITS'(prev_y_reg);
                d_reg[2]  <= D_BITS'(point_z) - D_BITS'(prev_z_reg);
                sq_reg    <= '0;
                sum_reg   <= '0;
                u_reg[0]  <= '0;
                u_reg[1]  <= '0;
                u_reg[2]  <= '0;
            end
            prx_pkg::OP_SQ:
            begin
                sq_reg  <= SQ_BITS'(d_sel * d_sel);
                sum_reg <= sum_reg + SUM_BITS'(sq_reg);
            end
            prx_pkg::OP_ROOT_INI:
            begin
                rad_reg  <= RAD_BITS'(sum_reg) << 16;
                rrem_reg <= '0;
                root_reg <= '0;
            end
            prx_pkg::OP_ROOT:
            begin
                rad_reg <= rad_reg << 2;
                if (rsh >= rtrial)
                begin
                    rrem_reg <= (LEN_BITS + 2)'(rsh - rtrial);
                    root_reg <= {root_reg[LEN_BITS-2:0], 1'b1};
                end
                else
                begin
                    rrem_reg <= (LEN_BITS + 2)'(rsh);
                    root_reg <= {root_reg[LEN_BITS-2:0], 1'b0};
                end
            end
            prx_pkg::OP_DIV_INI:
            begin
                rem_reg <= DIV_BITS'(n_val >> QB);
                num_reg <= n_val[QB-1:0];
                quo_reg <= '0;
                dvs_reg <= (cmd.comp == prx_pkg::COMP_AUX) ? DIV_BITS'(span_reg) : root_reg;
            end
            prx_pkg::OP_DIV:
            begin
                num_reg <= num_reg << 1;
                if (dtrial >= {1'b0, dvs_reg})
                begin
                    rem_reg <= DIV_BITS'(dtrial - {1'b0, dvs_reg});
                    quo_reg <= {quo_reg[QB-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= DIV_BITS'(dtrial);
                    quo_reg <= {quo_reg[QB-2:0], 1'b0};
                end
            end
            prx_pkg::OP_DIV_END:
            begin
                if (cmd.comp == prx_pkg::COMP_AUX)
                begin
                    t_reg <= t_sum[15:0];
                end
                else
                begin
                    u_reg[cmd.comp] <= d_sel[D_BITS-1] ? -$signed(q_clamp) : $signed(q_clamp);
                end
            end
            prx_pkg::OP_THK_MUL:
            begin
                thk_prod_reg <= 32'(tdiff_mag * c_val);
            end
            prx_pkg::OP_THK_FAR:
            begin
                t_reg <= {far_reg, 8'd0};
            end
            prx_pkg::OP_SCALE:
            begin
                prod_reg      <= 33'(u_sel) * 33'($signed({1'b0, t_reg}));
                prod_comp_reg <= cmd.comp;
                if (prod_comp_reg != prx_pkg::COMP_AUX)
                begin
                    pos_reg[prod_comp_reg] <= OUT_BITS'(p_pos);
                    neg_reg[prod_comp_reg] <= OUT_BITS'(p_neg);
                end
            end
            prx_pkg::OP_EMIT:
            begin
                lx_reg     <= (OUT_BITS'(prev_x_reg) <<< FRACTION_BITS) + pos_reg[1];
                ly_reg     <= (OUT_BITS'(prev_y_reg) <<< FRACTION_BITS) + neg_reg[0];
                lz_reg     <= (OUT_BITS'(prev_z_reg) <<< FRACTION_BITS) + pos_reg[2];
                rx_reg     <= (OUT_BITS'(prev_x_reg) <<< FRACTION_BITS) + neg_reg[1];
                ry_reg     <= (OUT_BITS'(prev_y_reg) <<< FRACTION_BITS) + pos_reg[0];
                rz_reg     <= (OUT_BITS'(prev_z_reg) <<< FRACTION_BITS) + pos_reg[2];
                prev_x_reg <= cur_x_reg;
                prev_y_reg <= cur_y_reg;
                prev_z_reg <= cur_z_reg;
            end
            default: ;
        endcase
    end

    assign status.have_prev = have_reg;
    assign status.len_zero  = (root_reg == '0);
    assign status.span_zero = (span_reg == 16'd0);

    assign left_x  = lx_reg;
    assign left_y  = ly_reg;
    assign left_z  = lz_reg;
    assign right_x = rx_reg;
    assign right_y = ry_reg;
    assign right_z = rz_reg;

endmodule
